// File: rtl/tglw_pkg.sv
// Package for the guide-line warp block: widths, request and config codes, queue entry and state types.
// No dependencies.
package tglw_pkg;
    localparam int GuideDepth = 1024;
    localparam int IdxBits    = 10;
    localparam int CoordBits  = 16;
    localparam int FracBits   = 16;
    localparam int ExtBits    = 15;
    localparam int CntBits    = 11;
    localparam int CfgIdxBits = 2;
    localparam int QDepth     = 2;

    typedef enum logic [2:0] {
        REQ_TOP     = 3'd0,
        REQ_BOT     = 3'd1,
        REQ_MEASURE = 3'd2,
        REQ_WARP    = 3'd3,
        REQ_BEGIN   = 3'd4
    } t_req;

    localparam logic [CfgIdxBits-1:0] CFG_TOP_COUNT = 2'd0;
    localparam logic [CfgIdxBits-1:0] CFG_BOT_COUNT = 2'd1;
    localparam logic [CfgIdxBits-1:0] CFG_BASE_W    = 2'd2;
    localparam logic [CfgIdxBits-1:0] CFG_BASE_H    = 2'd3;

    // warp job handed from front to back
    typedef struct packed {
        logic signed [CoordBits-1:0] x;
        logic signed [CoordBits-1:0] y;
        logic [ExtBits-1:0]          ew;
        logic [ExtBits-1:0]          eh;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIVX, ST_DIVY, ST_PICK, ST_READ, ST_MULT, ST_OUT
    } t_state;
endpackage

// File: rtl/tglw_stream_if.sv
// Valid/ready channel interface carrying a parameterized payload.
// Depends on nothing.
interface tglw_stream_if #(parameter int W = 32) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/text_guide_line_warp.sv
// Top level of the guide-line warp block.
// Depends on tglw_pkg, tglw_stream_if, tglw_front, tglw_queue, tglw_back.
//
// Usage:
//  - i_in carries request beats {req_type, entry_index, coord_x, coord_y}.
//    Guide writes, measure and begin-string beats finish in the cycle they
//    are accepted and give no result; a warp beat gives one result beat
//    {warped_x, warped_y} on o_out.
//  - A warp goes from acceptance to o_out valid through these steps: pop
//    the queue, then for each of the two scales 31 serial divider steps
//    and a step to select clamp or quotient, then index pick, table read,
//    blend and rounding.
//  - The back starts a new warp only after o_out has taken the last result;
//    other beats are taken one per cycle while the two-entry job queue has
//    room. Guide writes wait until no warp is pending in the queue or back.
//  - The front captures the extent with each warp job, so later measure
//    beats do not disturb jobs already queued.
//  - Configuration writes on i_cfg_* take effect the next cycle; write
//    only while idle.
//  - Reset (synchronous, active low) restores counts 2, base extent 1,
//    and empties the queue; guide tables are not cleared.
//  - When o_out is stalled, the result register holds and the back stops
//    taking jobs; the queue fills and then i_in.ready drops.
module text_guide_line_warp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tglw_pkg::CfgIdxBits-1:0] i_cfg_idx,
    input  logic [tglw_pkg::ExtBits-1:0]    i_cfg_data,
    tglw_stream_if.sink                     i_in,
    tglw_stream_if.source                   o_out
);
    localparam int CB = tglw_pkg::CoordBits;
    tglw_pkg::t_job w_pjob, w_qjob;
    logic w_push, w_full, w_pop, w_empty, w_twe, w_bwe, w_busy, w_pend;
    logic [tglw_pkg::CntBits-1:0] w_tc, w_bc;

    // a warp is pending while the queue holds one or the back works on one
    assign w_pend = !w_empty || w_busy;

    // input data layout: {req[2:0], idx[9:0], x, y}
    tglw_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_req(i_in.data[2*CB+tglw_pkg::IdxBits +: 3]),
        .i_idx(i_in.data[2*CB +: tglw_pkg::IdxBits]),
        .i_x(i_in.data[CB +: CB]), .i_y(i_in.data[0 +: CB]),
        .i_full(w_full), .i_busy(w_pend), .o_push(w_push), .o_job(w_pjob),
        .o_top_we(w_twe), .o_bot_we(w_bwe), .o_top_count(w_tc), .o_bot_count(w_bc));

    tglw_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_pjob), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_job(w_qjob));

    tglw_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_job(w_qjob), .o_pop(w_pop),
        .o_busy(w_busy),
        .i_top_count(w_tc), .i_bot_count(w_bc),
        .i_top_we(w_twe), .i_bot_we(w_bwe),
        .i_waddr(i_in.data[2*CB +: tglw_pkg::IdxBits]), .i_wdata(i_in.data[2*CB-1:0]),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_data(o_out.data));
endmodule

// File: rtl/tglw_ram.sv
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module tglw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/tglw_queue.sv
// Short job queue between front and back.
// Depends on tglw_pkg.
module tglw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tglw_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tglw_pkg::t_job  o_job
);
    tglw_pkg::t_job r_q [tglw_pkg::QDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    assign o_full  = (r_cnt == 2'(tglw_pkg::QDepth));
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_q[r_rp];
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// File: rtl/tglw_back.sv
// Back end: serial divider for the two scales, guide lookup and blend.
// Depends on tglw_pkg and tglw_ram.
module tglw_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  tglw_pkg::t_job                    i_job,
    output logic                              o_pop,
    output logic                              o_busy,
    input  logic [tglw_pkg::CntBits-1:0]      i_top_count,
    input  logic [tglw_pkg::CntBits-1:0]      i_bot_count,
    input  logic                              i_top_we,
    input  logic                              i_bot_we,
    input  logic [tglw_pkg::IdxBits-1:0]      i_waddr,
    input  logic [2*tglw_pkg::CoordBits-1:0]  i_wdata,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2*tglw_pkg::CoordBits-1:0]  o_data
);
    localparam int CB = tglw_pkg::CoordBits;
    localparam int FB = tglw_pkg::FracBits;
    localparam int EB = tglw_pkg::ExtBits;
    localparam int IB = tglw_pkg::IdxBits;
    localparam int NB = EB + FB;          // dividend width
    localparam int SB = FB + 1;           // scale incl. one

    tglw_pkg::t_state r_st, n_st;
    tglw_pkg::t_job   r_job;
    logic [NB-1:0]    r_quo;   // dividend shifting out, quotient shifting in
    logic [EB-1:0]    r_rem;
    logic [4:0]       r_cnt;
    logic [SB-1:0]    r_sx, r_sy;
    logic [IB-1:0]    r_ti, r_bi;
    logic signed [CB+SB+1:0] r_ax, r_ay;
    logic             r_ov;
    logic [2*CB-1:0]  r_od;
    logic [2*CB-1:0]  w_top, w_bot;

    tglw_ram #(.WIDTH(2*CB), .DEPTH(tglw_pkg::GuideDepth)) u_top (
        .i_clk, .i_we(i_top_we), .i_waddr(i_waddr), .i_wdata(i_wdata),
        .i_raddr(r_ti), .o_rdata(w_top));
    tglw_ram #(.WIDTH(2*CB), .DEPTH(tglw_pkg::GuideDepth)) u_bot (
        .i_clk, .i_we(i_bot_we), .i_waddr(i_waddr), .i_wdata(i_wdata),
        .i_raddr(r_bi), .o_rdata(w_bot));

    // saturating scale setup; top bit set when clamped
    function automatic logic [SB:0] clamp_of(input logic signed [CB-1:0] c,
                                             input logic [EB-1:0] e);
        logic [SB:0] r;
        r = '0;
        if (c <= 0) r = {1'b1, {SB{1'b0}}};
        else if ({1'b0, c} >= {{(CB+1-EB){1'b0}}, e}) r = {2'b11, {FB{1'b0}}};
        return r;
    endfunction

    function automatic logic [IB-1:0] pick(input logic [SB-1:0] s,
                                           input logic [tglw_pkg::CntBits-1:0] cnt);
        logic [tglw_pkg::CntBits-1:0] n;
        logic [SB+tglw_pkg::CntBits-1:0] p;
        logic [tglw_pkg::CntBits:0] idx;
        n = cnt;
        if (n < 1) n = tglw_pkg::CntBits'(1);
        if (n > tglw_pkg::CntBits'(tglw_pkg::GuideDepth))
            n = tglw_pkg::CntBits'(tglw_pkg::GuideDepth);
        n = n - 1'b1;
        p = s * n;
        idx = (tglw_pkg::CntBits+1)'(p >> FB);
        if (idx > {1'b0, n}) idx = {1'b0, n};
        return idx[IB-1:0];
    endfunction

    function automatic logic signed [CB+SB+1:0] mix(input logic signed [CB-1:0] b,
                                                   input logic signed [CB-1:0] t,
                                                   input logic [SB-1:0] s);
        logic signed [SB:0] ss, rs;
        ss = $signed({1'b0, s});
        rs = $signed({1'b0, SB'(1 << FB)}) - ss;
        return (CB+SB+2)'(b * ss) + (CB+SB+2)'(t * rs);
    endfunction

    function automatic logic [CB-1:0] trunc(input logic signed [CB+SB+1:0] a);
        logic signed [CB+SB+1:0] q;
        q = a >>> FB;
        if (a < 0 && a[FB-1:0] != '0) q = q + 1;
        return q[CB-1:0];
    endfunction

    logic [NB-1:0] n_quo;
    logic [EB:0]   n_rem, w_sh;
    logic [EB-1:0] w_div;
    logic [SB:0]   w_cl;
    logic          w_y;

    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_busy  = (r_st != tglw_pkg::ST_IDLE);
    assign w_y     = (r_st == tglw_pkg::ST_DIVY);
    assign w_div   = w_y ? r_job.eh : r_job.ew;
    assign w_sh    = {r_rem, r_quo[NB-1]};

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        n_quo = {r_quo[NB-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, w_div}) begin
            n_rem = w_sh - {1'b0, w_div};
            n_quo[0] = 1'b1;
        end
        w_cl = clamp_of(w_y ? r_job.y : r_job.x, w_div);
        unique case (r_st)
            tglw_pkg::ST_IDLE: if (!i_empty && !r_ov) begin
                o_pop = 1'b1; n_st = tglw_pkg::ST_DIVX;
            end
            tglw_pkg::ST_DIVX: if (r_cnt == 5'(NB)) n_st = tglw_pkg::ST_DIVY;
            tglw_pkg::ST_DIVY: if (r_cnt == 5'(NB)) n_st = tglw_pkg::ST_PICK;
            tglw_pkg::ST_PICK: n_st = tglw_pkg::ST_READ;
            tglw_pkg::ST_READ: n_st = tglw_pkg::ST_MULT;
            tglw_pkg::ST_MULT: n_st = tglw_pkg::ST_OUT;
            tglw_pkg::ST_OUT:  n_st = tglw_pkg::ST_IDLE;
            default:           n_st = tglw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tglw_pkg::ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (o_valid && i_ready) r_ov <= 1'b0;
            if (r_st == tglw_pkg::ST_OUT) r_ov <= 1'b1;
        end
        unique case (r_st)
            tglw_pkg::ST_IDLE: begin
                r_job <= i_job;
                r_cnt <= '0;
                r_rem <= '0;
                r_quo <= {i_job.x[EB-1:0], FB'(0)};
            end
            tglw_pkg::ST_DIVX, tglw_pkg::ST_DIVY: begin
                if (r_cnt == 5'(NB)) begin
                    // finish: pick clamp or quotient
                    if (w_cl[SB]) begin
                        if (w_y) r_sy <= w_cl[SB-1:0]; else r_sx <= w_cl[SB-1:0];
                    end else begin
                        if (w_y) r_sy <= {1'b0, r_quo[FB-1:0]};
                        else     r_sx <= {1'b0, r_quo[FB-1:0]};
                    end
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_quo <= {r_job.y[EB-1:0], FB'(0)};
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                    r_rem <= n_rem[EB-1:0];
                    r_quo <= n_quo;
                end
            end
            tglw_pkg::ST_PICK: begin
                r_ti <= pick(r_sx, i_top_count);
                r_bi <= pick(r_sx, i_bot_count);
            end
            tglw_pkg::ST_MULT: begin
                r_ax <= mix(w_bot[2*CB-1:CB], w_top[2*CB-1:CB], r_sy);
                r_ay <= mix(w_bot[CB-1:0], w_top[CB-1:0], r_sy);
            end
            tglw_pkg::ST_OUT: r_od <= {trunc(r_ax), trunc(r_ay)};
            default: ;
        endcase
    end
endmodule

// File: rtl/tglw_front.sv
// Front end: config registers, extent tracking, guide writes and warp job issue.
// Depends on tglw_pkg.
module tglw_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tglw_pkg::CfgIdxBits-1:0]   i_cfg_idx,
    input  logic [tglw_pkg::ExtBits-1:0]      i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_req,
    input  logic [tglw_pkg::IdxBits-1:0]      i_idx,
    input  logic signed [tglw_pkg::CoordBits-1:0] i_x,
    input  logic signed [tglw_pkg::CoordBits-1:0] i_y,
    input  logic                              i_full,
    input  logic                              i_busy,
    output logic                              o_push,
    output tglw_pkg::t_job                    o_job,
    output logic                              o_top_we,
    output logic                              o_bot_we,
    output logic [tglw_pkg::CntBits-1:0]      o_top_count,
    output logic [tglw_pkg::CntBits-1:0]      o_bot_count
);
    localparam int EB = tglw_pkg::ExtBits;
    logic [EB-1:0] r_bw, r_bh, r_ew, r_eh;
    logic [tglw_pkg::CntBits-1:0] r_tc, r_bc;
    logic w_acc, w_wr;

    // hold guide writes while an earlier warp may still read the tables
    assign w_wr        = (i_req == tglw_pkg::REQ_TOP) || (i_req == tglw_pkg::REQ_BOT);
    assign o_ready     = !i_full && !(w_wr && i_busy);
    assign w_acc       = i_valid && o_ready;
    assign o_top_we    = w_acc && (i_req == tglw_pkg::REQ_TOP);
    assign o_bot_we    = w_acc && (i_req == tglw_pkg::REQ_BOT);
    assign o_push      = w_acc && (i_req == tglw_pkg::REQ_WARP);
    assign o_job       = '{x: i_x, y: i_y, ew: r_ew, eh: r_eh};
    assign o_top_count = r_tc;
    assign o_bot_count = r_bc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= 11'd2; r_bc <= 11'd2;
            r_bw <= EB'(1); r_bh <= EB'(1);
            r_ew <= EB'(1); r_eh <= EB'(1);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tglw_pkg::CFG_TOP_COUNT: r_tc <= i_cfg_data[tglw_pkg::CntBits-1:0];
                    tglw_pkg::CFG_BOT_COUNT: r_bc <= i_cfg_data[tglw_pkg::CntBits-1:0];
                    tglw_pkg::CFG_BASE_W:    r_bw <= i_cfg_data;
                    tglw_pkg::CFG_BASE_H:    r_bh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_acc && i_req == tglw_pkg::REQ_MEASURE) begin
                // raise the extent; a positive 16-bit value above 15 bits cannot occur
                // beyond 32767, so compare on the low bits when positive
                if (!i_x[15] && i_x[EB-1:0] > r_ew) r_ew <= i_x[EB-1:0];
                if (!i_y[15] && i_y[EB-1:0] > r_eh) r_eh <= i_y[EB-1:0];
            end
            if (w_acc && i_req == tglw_pkg::REQ_BEGIN) begin
                r_ew <= (r_bw == '0) ? EB'(1) : r_bw;
                r_eh <= (r_bh == '0) ? EB'(1) : r_bh;
            end
        end
    end
endmodule
